// ===== design/stfc_pkg.sv =====
// stfc_pkg: shared types, constants and the channel saturation function
// for the scalar to false color block; no dependencies
`timescale 1ns / 1ps

package stfc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_MODE  = 2'd0,
    CFG_RANGE_MIN = 2'd1,
    CFG_RANGE_MAX = 2'd2
  } cfg_idx_t;

  // colormap families, taken from the upper three bits of the mode
  typedef enum logic [2:0] {
    FAM_GREY        = 3'd0,
    FAM_GREEN_RED   = 3'd1,
    FAM_BLUE_RED    = 3'd2,
    FAM_BGR         = 3'd3,
    FAM_RED_DKGREEN = 3'd4,
    FAM_CYAN        = 3'd5,
    FAM_RED_YELLOW  = 3'd6,
    FAM_NONE        = 3'd7
  } fam_t;

  localparam logic [3:0] MODE_LAST = 4'd13;

  // fixed point constants, Q16
  localparam logic signed [25:0] QONE_S     = 26'sd65536;
  localparam logic signed [25:0] Q_THREE_S  = 26'sd196608;
  localparam logic signed [23:0] SQ99_S     = 24'sd64233;
  localparam logic [24:0]        XMAX_MAG   = 25'd8388607;
  localparam logic [24:0]        XMIN_MAG   = 25'd8388608;
  localparam logic signed [23:0] XMAX_S     = 24'sh7FFFFF;
  localparam logic signed [23:0] XMIN_S     = 24'sh800000;
  localparam logic [7:0]         CH_FULL    = 8'd255;
  localparam logic [7:0]         DKG_FLOOR  = 8'd63;
  // ceil(2^24 / 9), exact for dividends below 2^21
  localparam logic [20:0]        RECIP9     = 21'd1864136;
  localparam int                 RECIP9_SH  = 24;

  // word fields that ride along the tail of the pipe
  typedef struct packed {
    logic signed [23:0] x;
    logic [3:0]         mode;
    logic               ok;
    logic [7:0]         sr;
    logic [7:0]         sg;
    logic [7:0]         sb;
    logic [7:0]         glin;
  } tail_t;

  // channel saturation: 0 when v <= 0, else min(255, floor(255 v / 2^16))
  function automatic logic [7:0] chan(input logic signed [25:0] v);
    logic signed [34:0] p;
    logic signed [34:0] r;
    p = (35'(v) <<< 8) - 35'(v);
    r = p >>> 16;
    if (v <= 26'sd0) begin
      return 8'd0;
    end else if (r > 35'sd255) begin
      return CH_FULL;
    end else begin
      return r[7:0];
    end
  endfunction

endpackage

// ===== design/scalar_to_false_color.sv =====
// scalar_to_false_color: pipelined colormap from a signed sample to rgb888
// depends on stfc_pkg (types, constants, chan function)
`timescale 1ns / 1ps

// channel   ports                                    handshake
// input     in_sample                                start & !busy
// config    cfg_index, cfg_data                      cfg_we
// result    out_red, out_green, out_blue, out_ok     out_valid, one cycle
//
// one word enters every clock while busy is low, and its result comes out in order.
// most of the pipe is the 25 stage restoring divider that normalizes
// the sample, followed by a 16 stage square root and the table lookups.
// reset is synchronous, active low; busy is high only while in reset.
// the receiver cannot stall, so the pipe advances on every clock.
module scalar_to_false_color #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [23:0]                 in_sample,
  input  logic                               cfg_we,
  input  logic [stfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [23:0]                        cfg_data,
  output logic                               out_valid,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_ok
);
  import stfc_pkg::*;

  localparam int PH_BITS   = SINE_TABLE_BITS + 2;
  localparam int TBL_N     = 1 << SINE_TABLE_BITS;
  localparam int IDX_W     = SINE_TABLE_BITS + 1;
  localparam int DIV_STG   = 25;
  localparam int SQRT_STG  = 16;
  localparam int LATENCY   = 3 + DIV_STG + 2 + SQRT_STG + 5;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [16:0] rom_t [0:TBL_N];

  // quarter wave sine table, Q16, built from a taylor series in Q30
  function automatic rom_t build_rom();
    rom_t               t;
    logic [63:0]        a;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] e;
    for (int k = 0; k <= TBL_N; k++) begin
      a    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      term = a;
      sum  = $signed(a);
      for (int n = 1; n <= 10; n++) begin
        term = (term * a) >> 30;
        term = (term * a) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = (sum + 64'sd8192) >>> 14;
      if (e > 64'sd65536) begin
        e = 64'sd65536;
      end
      t[k] = 17'(e);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // sine of a phase in units of 1/2^PH_BITS turn, quadrant symmetry
  function automatic logic signed [17:0] sin_ph(input logic [PH_BITS-1:0] p);
    logic [1:0]       q;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] ni;
    logic [16:0]      v;
    q  = p[PH_BITS-1 -: 2];
    i  = {1'b0, p[SINE_TABLE_BITS-1:0]};
    ni = IDX_W'(TBL_N) - i;
    v  = q[0] ? SINE_ROM[ni] : SINE_ROM[i];
    return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  logic in_fire;
  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  // configuration registers
  logic [3:0]         map_mode_r;
  logic signed [23:0] range_min_r;
  logic signed [23:0] range_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r  <= 4'd0;
      range_min_r <= 24'sd0;
      range_max_r <= 24'sd255;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAP_MODE:  map_mode_r  <= cfg_data[3:0];
        CFG_RANGE_MIN: range_min_r <= cfg_data;
        CFG_RANGE_MAX: range_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: offset and span
  logic               s1_valid_r;
  logic signed [24:0] s1_num_r;
  logic signed [24:0] s1_den_r;
  logic [3:0]         s1_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r  <= {in_sample[23], in_sample} - {range_min_r[23], range_min_r};
    s1_den_r  <= {range_max_r[23], range_max_r} - {range_min_r[23], range_min_r};
    s1_mode_r <= map_mode_r;
  end

  // stage 2: magnitudes and quotient sign
  logic        s2_valid_r;
  logic [24:0] s2_an_r;
  logic [24:0] s2_ad_r;
  logic        s2_neg_r;
  logic        s2_ok_r;
  logic [3:0]  s2_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_an_r   <= s1_num_r[24] ? 25'(-s1_num_r) : 25'(s1_num_r);
    s2_ad_r   <= s1_den_r[24] ? 25'(-s1_den_r) : 25'(s1_den_r);
    s2_neg_r  <= s1_num_r[24] ^ s1_den_r[24];
    s2_ok_r   <= (s1_den_r != 25'sd0) && (s1_mode_r <= MODE_LAST);
    s2_mode_r <= s1_mode_r;
  end

  // divider: index 0 holds the initial remainder, one quotient bit per stage
  logic        dv_valid_r [0:DIV_STG];
  logic [24:0] dv_rem_r   [0:DIV_STG];
  logic [24:0] dv_dvd_r   [0:DIV_STG];
  logic [24:0] dv_q_r     [0:DIV_STG];
  logic [24:0] dv_ad_r    [0:DIV_STG];
  logic        dv_neg_r   [0:DIV_STG];
  logic        dv_ovf_r   [0:DIV_STG];
  logic        dv_ok_r    [0:DIV_STG];
  logic [3:0]  dv_mode_r  [0:DIV_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else begin
      dv_valid_r[0] <= s2_valid_r;
    end
  end

  // quotient of 2^25 or more means saturation
  always_ff @(posedge clk) begin
    dv_rem_r[0]  <= {9'd0, s2_an_r[24:9]};
    dv_dvd_r[0]  <= {s2_an_r[8:0], 16'd0};
    dv_q_r[0]    <= 25'd0;
    dv_ad_r[0]   <= s2_ad_r;
    dv_neg_r[0]  <= s2_neg_r;
    dv_ovf_r[0]  <= {9'd0, s2_an_r} >= {s2_ad_r, 9'd0};
    dv_ok_r[0]   <= s2_ok_r;
    dv_mode_r[0] <= s2_mode_r;
  end

  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    logic [25:0] trial;
    logic [25:0] diff;
    logic        ge;
    assign trial = {dv_rem_r[k], dv_dvd_r[k][24]};
    assign diff  = trial - {1'b0, dv_ad_r[k]};
    assign ge    = trial >= {1'b0, dv_ad_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k+1] <= 1'b0;
      end else begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k+1]  <= ge ? diff[24:0] : trial[24:0];
      dv_dvd_r[k+1]  <= {dv_dvd_r[k][23:0], 1'b0};
      dv_q_r[k+1]    <= {dv_q_r[k][23:0], ge};
      dv_ad_r[k+1]   <= dv_ad_r[k];
      dv_neg_r[k+1]  <= dv_neg_r[k];
      dv_ovf_r[k+1]  <= dv_ovf_r[k];
      dv_ok_r[k+1]   <= dv_ok_r[k];
      dv_mode_r[k+1] <= dv_mode_r[k];
    end
  end

  // x1: signed saturation of the quotient
  logic               x1_valid_r;
  logic signed [23:0] x1_x_r;
  logic               x1_ok_r;
  logic [3:0]         x1_mode_r;
  logic [24:0]        qm;

  assign qm = dv_q_r[DIV_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_valid_r <= 1'b0;
    end else begin
      x1_valid_r <= dv_valid_r[DIV_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (!dv_neg_r[DIV_STG]) begin
      x1_x_r <= (dv_ovf_r[DIV_STG] || qm > XMAX_MAG) ? XMAX_S : qm[23:0];
    end else begin
      x1_x_r <= (dv_ovf_r[DIV_STG] || qm > XMIN_MAG) ? XMIN_S : 24'(-qm);
    end
    x1_ok_r   <= dv_ok_r[DIV_STG];
    x1_mode_r <= dv_mode_r[DIV_STG];
  end

  // x2: inverse maps use 1 - x, then square root setup
  logic               x_inv;
  logic signed [24:0] x_flip;
  logic signed [23:0] x2_nxt;

  assign x_inv  = x1_mode_r[0] && (fam_t'(x1_mode_r[3:1]) != FAM_GREY);
  assign x_flip = 25'sd65536 - {x1_x_r[23], x1_x_r};

  always_comb begin
    if (!x_inv) begin
      x2_nxt = x1_x_r;
    end else if (x_flip > 25'sd8388607) begin
      x2_nxt = XMAX_S;
    end else if (x_flip < -25'sd8388608) begin
      x2_nxt = XMIN_S;
    end else begin
      x2_nxt = x_flip[23:0];
    end
  end

  // square root pipe: index 0 is the x2 register
  logic               sq_valid_r [0:SQRT_STG];
  logic [31:0]        sq_v_r     [0:SQRT_STG];
  logic [17:0]        sq_rem_r   [0:SQRT_STG];
  logic [15:0]        sq_root_r  [0:SQRT_STG];
  logic signed [23:0] sq_x_r     [0:SQRT_STG];
  logic               sq_ok_r    [0:SQRT_STG];
  logic [3:0]         sq_mode_r  [0:SQRT_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else begin
      sq_valid_r[0] <= x1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_v_r[0]    <= (x2_nxt >= 24'sd0 && x2_nxt < SQ99_S) ? {x2_nxt[15:0], 16'd0} : 32'd0;
    sq_rem_r[0]  <= 18'd0;
    sq_root_r[0] <= 16'd0;
    sq_x_r[0]    <= x2_nxt;
    sq_ok_r[0]   <= x1_ok_r;
    sq_mode_r[0] <= x1_mode_r;
  end

  for (genvar k = 0; k < SQRT_STG; k++) begin : g_sqrt
    logic [19:0] rt;
    logic [19:0] trial;
    logic [19:0] diff;
    logic        ge;
    assign rt    = {sq_rem_r[k], sq_v_r[k][31:30]};
    assign trial = {2'b00, sq_root_r[k], 2'b01};
    assign diff  = rt - trial;
    assign ge    = rt >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k+1] <= 1'b0;
      end else begin
        sq_valid_r[k+1] <= sq_valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[k+1]  <= ge ? diff[17:0] : rt[17:0];
      sq_root_r[k+1] <= {sq_root_r[k][14:0], ge};
      sq_v_r[k+1]    <= {sq_v_r[k][29:0], 2'b00};
      sq_x_r[k+1]    <= sq_x_r[k];
      sq_ok_r[k+1]   <= sq_ok_r[k];
      sq_mode_r[k+1] <= sq_mode_r[k];
    end
  end

  // p1: phase dividends, quartic magnitude, cheap colormaps
  logic signed [23:0] px;
  logic [15:0]        sq;
  logic [39:0]        w_sq;
  logic [39:0]        w_x;
  logic [39:0]        half_w;
  logic [39:0]        full_w;
  logic signed [25:0] px26;
  logic signed [25:0] dx26;
  logic signed [24:0] u_q;
  logic [24:0]        m_q;
  logic signed [33:0] d4;
  logic signed [33:0] t4;
  logic signed [33:0] gv4;
  logic [7:0]         sr_nxt, sg_nxt, sb_nxt, gl_nxt;

  assign px   = sq_x_r[SQRT_STG];
  assign sq   = sq_root_r[SQRT_STG];
  assign w_sq = ((40'(sq) << 3) + (40'(sq) << 1)) << PH_BITS;
  assign w_x  = 40'(px[15:0]) << PH_BITS;
  assign half_w = (w_x + 40'd65536) >> 17;
  assign full_w = (w_x + 40'd32768) >> 16;
  assign px26 = 26'(px);
  assign dx26 = QONE_S - px26;
  assign u_q  = 25'sd65536 - {px[23], px};
  assign m_q  = u_q[24] ? 25'(-u_q) : 25'(u_q);
  assign d4   = 34'(Q_THREE_S) - 34'(px26);
  assign t4   = (d4 <<< 8) - d4;
  assign gv4  = (t4 <= 34'sd0) ? 34'sd0 : (t4 >>> 17);
  assign gl_nxt = chan(px26);

  always_comb begin
    sr_nxt = 8'd0;
    sg_nxt = 8'd0;
    sb_nxt = 8'd0;
    case (fam_t'(sq_mode_r[SQRT_STG][3:1]))
      FAM_GREY: begin
        sr_nxt = sq_mode_r[SQRT_STG][0] ? CH_FULL - gl_nxt : gl_nxt;
        sg_nxt = sr_nxt;
        sb_nxt = sr_nxt;
      end
      FAM_GREEN_RED: begin
        if (px < 24'sd0) begin
          sg_nxt = CH_FULL;
        end else if (px26 >= QONE_S) begin
          sr_nxt = CH_FULL;
        end else begin
          sr_nxt = chan(px26 <<< 1);
          sg_nxt = chan(dx26 <<< 1);
        end
      end
      FAM_RED_DKGREEN: begin
        if (px26 > QONE_S) begin
          if (gv4 > 34'sd255) begin
            sg_nxt = CH_FULL;
          end else if (gv4 < 34'sd63) begin
            sg_nxt = DKG_FLOOR;
          end else begin
            sg_nxt = gv4[7:0];
          end
        end else if (px < 24'sd0) begin
          sr_nxt = CH_FULL;
        end else begin
          sg_nxt = chan(px26 <<< 1);
          sr_nxt = chan(dx26 <<< 1);
        end
      end
      default: ;
    endcase
  end

  logic                 p1_valid_r;
  logic [19:0]          p1_v1_r;
  logic [19:0]          p1_v2_r;
  logic [15:0]          p1_m_r;
  logic                 p1_qbig_r;
  logic [PH_BITS-1:0]   p1_phr_r, p1_phg_r, p1_phb_r;
  tail_t                p1_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= sq_valid_r[SQRT_STG];
    end
  end

  always_ff @(posedge clk) begin
    p1_v1_r   <= 20'((w_sq + 40'd1179648) >> 18);
    p1_v2_r   <= 20'((w_sq + 40'd589824) >> 17);
    p1_m_r    <= m_q[15:0];
    p1_qbig_r <= m_q[24:16] != 9'd0;
    p1_phr_r  <= PH_BITS'(half_w) + PH_BITS'(3 * TBL_N);
    p1_phg_r  <= PH_BITS'(full_w) + PH_BITS'(3 * TBL_N);
    p1_phb_r  <= PH_BITS'(half_w) + PH_BITS'(TBL_N);
    p1_tl_r   <= '{x: px, mode: sq_mode_r[SQRT_STG], ok: sq_ok_r[SQRT_STG],
                   sr: sr_nxt, sg: sg_nxt, sb: sb_nxt, glin: gl_nxt};
  end

  // p2: divide by 9 through the reciprocal, u^2, sine reads for bgr
  logic [40:0] prod1, prod2;
  logic [31:0] msq;

  assign prod1 = 41'(p1_v1_r) * 41'(RECIP9);
  assign prod2 = 41'(p1_v2_r) * 41'(RECIP9);
  assign msq   = 32'(p1_m_r) * 32'(p1_m_r);

  logic                p2_valid_r;
  logic [PH_BITS-1:0]  p2_p1_r, p2_p2_r;
  logic [15:0]         p2_u2_r;
  logic                p2_qbig_r;
  logic signed [17:0]  p2_sr_r, p2_sg_r, p2_sb_r;
  tail_t               p2_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_p1_r   <= prod1[RECIP9_SH +: PH_BITS];
    p2_p2_r   <= prod2[RECIP9_SH +: PH_BITS];
    p2_u2_r   <= msq[31:16];
    p2_qbig_r <= p1_qbig_r;
    p2_sr_r   <= sin_ph(p1_phr_r);
    p2_sg_r   <= sin_ph(p1_phg_r);
    p2_sb_r   <= sin_ph(p1_phb_r);
    p2_tl_r   <= p1_tl_r;
  end

  // p3: u^4, sine reads for blue-red, bgr channels
  logic [31:0] u2sq;
  assign u2sq = 32'(p2_u2_r) * 32'(p2_u2_r);

  logic               p3_valid_r;
  logic [15:0]        p3_u4_r;
  logic               p3_qbig_r;
  logic signed [17:0] p3_s1_r, p3_s2_r;
  logic [7:0]         p3_cr_r, p3_cg_r, p3_cb_r;
  tail_t              p3_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_u4_r   <= u2sq[31:16];
    p3_qbig_r <= p2_qbig_r;
    p3_s1_r   <= sin_ph(p2_p1_r);
    p3_s2_r   <= sin_ph(p2_p2_r);
    p3_cr_r   <= chan(26'(p2_sr_r));
    p3_cg_r   <= chan(26'(p2_sg_r));
    p3_cb_r   <= chan(26'(p2_sb_r));
    p3_tl_r   <= p2_tl_r;
  end

  // p4: quartic and blue-red channels
  logic               p4_valid_r;
  logic [7:0]         p4_qch_r;
  logic [7:0]         p4_fr_r, p4_fg_r, p4_fb_r;
  logic [7:0]         p4_cr_r, p4_cg_r, p4_cb_r;
  tail_t              p4_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_valid_r <= 1'b0;
    end else begin
      p4_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p4_qch_r <= p3_qbig_r ? 8'd0 : chan(QONE_S - 26'(p3_u4_r));
    p4_fr_r  <= chan(26'(p3_s1_r));
    p4_fg_r  <= chan(26'(p3_s2_r));
    p4_fb_r  <= chan(QONE_S - 26'(p3_s1_r));
    p4_cr_r  <= p3_cr_r;
    p4_cg_r  <= p3_cg_r;
    p4_cb_r  <= p3_cb_r;
    p4_tl_r  <= p3_tl_r;
  end

  // p5: colormap select into the output register
  logic [7:0] r_nxt, g_nxt, b_nxt;
  logic       edge_neg, edge_hi;

  assign edge_neg = p4_tl_r.x < 24'sd0;
  assign edge_hi  = p4_tl_r.x >= SQ99_S;

  always_comb begin
    r_nxt = 8'd0;
    g_nxt = 8'd0;
    b_nxt = 8'd0;
    if (p4_tl_r.ok) begin
      case (fam_t'(p4_tl_r.mode[3:1]))
        FAM_GREY, FAM_GREEN_RED, FAM_RED_DKGREEN: begin
          r_nxt = p4_tl_r.sr;
          g_nxt = p4_tl_r.sg;
          b_nxt = p4_tl_r.sb;
        end
        FAM_BLUE_RED: begin
          if (edge_neg) begin
            b_nxt = CH_FULL;
          end else if (edge_hi) begin
            r_nxt = CH_FULL;
          end else begin
            r_nxt = p4_fr_r;
            g_nxt = p4_fg_r;
            b_nxt = p4_fb_r;
          end
        end
        FAM_BGR: begin
          if (edge_neg) begin
            b_nxt = CH_FULL;
          end else if (edge_hi) begin
            r_nxt = CH_FULL;
          end else begin
            r_nxt = p4_cr_r;
            g_nxt = p4_cg_r;
            b_nxt = p4_cb_r;
          end
        end
        FAM_CYAN: begin
          g_nxt = p4_tl_r.glin;
          b_nxt = p4_qch_r;
        end
        FAM_RED_YELLOW: begin
          r_nxt = p4_qch_r;
          g_nxt = p4_tl_r.glin;
        end
        default: ;
      endcase
    end
  end

  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic       out_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_red_r   <= r_nxt;
    out_green_r <= g_nxt;
    out_blue_r  <= b_nxt;
    out_ok_r    <= p4_tl_r.ok;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_ok    = out_ok_r;

`ifndef SYNTHESIS
  // every accepted word yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##LATENCY out_valid)
    else $error("result missing after accepted word");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, LATENCY))
    else $error("result without an accepted word");

  // a rejected word comes out black
  a_invalid_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_red == 8'd0 && out_green == 8'd0 &&
                                out_blue == 8'd0))
    else $error("invalid result is not black");
`endif

endmodule

// ===== tb/tb_scalar_to_false_color.sv =====
// tb_scalar_to_false_color: self-checking testbench for the false color mapper
// depends on stfc_pkg and scalar_to_false_color; keeps its own colormap predictor
`timescale 1ns / 1ps

module tb_scalar_to_false_color;
  import stfc_pkg::*;

  localparam int TBL_BITS  = 10;
  localparam int TBL_SIZE  = 1 << TBL_BITS;
  localparam int PH_W      = TBL_BITS + 2;
  localparam int QUIET_MIN = 60;

  typedef enum logic [1:0] {
    OP_WORD,
    OP_CFG,
    OP_DRAIN
  } op_t;

  typedef struct {
    op_t         op;
    cfg_idx_t    idx;
    logic [23:0] val;
    int          gap;
  } pend_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ok;
  } color_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] in_sample = '0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               out_valid;
  logic [7:0]         out_red, out_green, out_blue;
  logic               out_ok;

  pend_t  pend_q[$];
  color_t color_q[$];
  int     err_cnt = 0;
  int     quiet = 0;
  int     gap_left = 0;
  int     burst = 0;
  longint sine_rom[0:TBL_SIZE];

  // predictor copy of the registers
  logic [3:0]         map_mode_m = 4'd0;
  logic signed [23:0] rng_min_m = 24'sd0;
  logic signed [23:0] rng_max_m = 24'sd255;

  scalar_to_false_color #(.SINE_TABLE_BITS(TBL_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_sample(in_sample),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_ok(out_ok)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // quarter-wave sine table from a taylor series in Q30
  task automatic build_sine_rom();
    longint unsigned a, term;
    longint sum, e;
    for (int k = 0; k <= TBL_SIZE; k++) begin
      a = (64'd1686629713 * k) >> TBL_BITS;
      term = a;
      sum = longint'(a);
      for (int n = 1; n <= 10; n++) begin
        term = (term * a) >> 30;
        term = (term * a) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = (sum + 8192) >>> 14;
      if (e > 65536) e = 65536;
      sine_rom[k] = e;
    end
  endtask

  function automatic longint sine_at(longint unsigned ph);
    int unsigned p, quad, i;
    p = int'(ph) & ((1 << PH_W) - 1);
    quad = p >> TBL_BITS;
    i = p & (TBL_SIZE - 1);
    case (quad)
      0: return sine_rom[i];
      1: return sine_rom[TBL_SIZE - i];
      2: return -sine_rom[i];
      default: return -sine_rom[TBL_SIZE - i];
    endcase
  endfunction

  function automatic logic [7:0] to_chan(longint v);
    longint t;
    if (v <= 0) return 8'd0;
    t = (255 * v) >>> 16;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // 1 - (1 - x)^4 rise used by the cyan and yellow maps
  function automatic logic [7:0] quartic_chan(longint x);
    longint u;
    longint unsigned m, u2, u4;
    u = 65536 - x;
    m = (u < 0) ? -u : u;
    if (m >= 65536) return 8'd0;
    u2 = (m * m) >> 16;
    u4 = (u2 * u2) >> 16;
    return to_chan(65536 - longint'(u4));
  endfunction

  function automatic color_t map_color(logic signed [23:0] smp);
    longint num, den, x, t, gv;
    longint unsigned an, ad, qm, sq, w, p1, p2, half_ph, full_ph;
    longint s1;
    logic [2:0] fam;
    logic inv;
    logic [7:0] gr;
    color_t c;
    c = '{8'd0, 8'd0, 8'd0, 1'b0};
    num = longint'(smp) - longint'(rng_min_m);
    den = longint'(rng_max_m) - longint'(rng_min_m);
    if (den == 0 || map_mode_m > MODE_LAST) return c;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    qm = (an << 16) / ad;
    x = sat_q(((num < 0) != (den < 0)) ? -longint'(qm) : longint'(qm));
    fam = map_mode_m[3:1];
    inv = map_mode_m[0];
    c.ok = 1'b1;
    if (inv && fam != FAM_GREY) x = sat_q(65536 - x);
    case (fam_t'(fam))
      FAM_GREY: begin
        gr = (x < 0) ? 8'd0 : to_chan(x);
        if (inv) gr = 8'd255 - gr;
        c.red = gr; c.green = gr; c.blue = gr;
      end
      FAM_GREEN_RED: begin
        if (x < 0) c.green = 8'd255;
        else if (x >= 65536) c.red = 8'd255;
        else begin
          c.red = to_chan(2 * x);
          c.green = to_chan(2 * (65536 - x));
        end
      end
      FAM_BLUE_RED: begin
        if (x < 0) c.blue = 8'd255;
        else if (x >= 64233) c.red = 8'd255;
        else begin
          sq = floor_sqrt(longint'(x) << 16);
          w = (sq * 10) << PH_W;
          p1 = (w + 18 * 65536) / (36 * 65536);
          p2 = (w + 9 * 65536) / (18 * 65536);
          s1 = sine_at(p1);
          c.red = to_chan(s1);
          c.green = to_chan(sine_at(p2));
          c.blue = to_chan(65536 - s1);
        end
      end
      FAM_BGR: begin
        if (x < 0) c.blue = 8'd255;
        else if (x >= 64233) c.red = 8'd255;
        else begin
          w = longint'(x) << PH_W;
          half_ph = (w + 65536) >> 17;
          full_ph = (w + 32768) >> 16;
          c.red = to_chan(sine_at(half_ph + 3 * TBL_SIZE));
          c.green = to_chan(sine_at(full_ph + 3 * TBL_SIZE));
          c.blue = to_chan(sine_at(half_ph + TBL_SIZE));
        end
      end
      FAM_RED_DKGREEN: begin
        if (x > 65536) begin
          t = 255 * (196608 - x);
          gv = (t <= 0) ? 0 : (t >>> 17);
          if (gv > 255) gv = 255;
          if (gv < 63) gv = 63;
          c.green = gv[7:0];
        end else if (x < 0) c.red = 8'd255;
        else begin
          c.green = to_chan(2 * x);
          c.red = to_chan(2 * (65536 - x));
        end
      end
      FAM_CYAN: begin
        c.green = to_chan(x);
        c.blue = quartic_chan(x);
      end
      default: begin
        c.green = to_chan(x);
        c.red = quartic_chan(x);
      end
    endcase
    return c;
  endfunction

  // stimulus queue helpers
  task automatic add_word(logic [23:0] v);
    pend_t p;
    p.op = OP_WORD; p.idx = CFG_MAP_MODE; p.val = v;
    p.gap = (burst > 0) ? 0 : $urandom_range(0, 12);
    pend_q.insert(pend_q.size(), p);
  endtask

  task automatic add_cfg(cfg_idx_t idx, logic [23:0] v);
    pend_t p;
    p.op = OP_CFG; p.idx = idx; p.val = v; p.gap = 0;
    pend_q.insert(pend_q.size(), p);
  endtask

  task automatic add_setting(logic [3:0] mode, logic [23:0] lo, logic [23:0] hi);
    add_cfg(CFG_MAP_MODE, {20'd0, mode});
    add_cfg(CFG_RANGE_MIN, lo);
    add_cfg(CFG_RANGE_MAX, hi);
  endtask

  // driver: presents words and register writes, predicts on acceptance
  always @(posedge clk) begin
    logic nstart, nwe;
    pend_t p;
    if (rst_n) begin
      nstart = start;
      nwe = 1'b0;
      if (start && !busy) begin
        color_q.insert(color_q.size(), map_color(in_sample));
        nstart = 1'b0;
      end
      if (color_q.size() == 0 && !start) quiet <= quiet + 1;
      else quiet <= 0;
      if (!nstart && !cfg_we) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pend_q.size() > 0) begin
          p = pend_q[0];
          case (p.op)
            OP_WORD: begin
              void'(pend_q.pop_front());
              in_sample <= p.val;
              gap_left <= p.gap;
              nstart = 1'b1;
            end
            OP_CFG: begin
              if (color_q.size() == 0 && quiet >= QUIET_MIN) begin
                void'(pend_q.pop_front());
                nwe = 1'b1;
                cfg_index <= p.idx;
                cfg_data <= p.val;
                case (p.idx)
                  CFG_MAP_MODE:  map_mode_m <= p.val[3:0];
                  CFG_RANGE_MIN: rng_min_m <= p.val;
                  default:       rng_max_m <= p.val;
                endcase
              end
            end
            default: begin
              if (color_q.size() == 0) void'(pend_q.pop_front());
            end
          endcase
        end
      end
      start <= nstart;
      cfg_we <= nwe;
    end
  end

  // monitor: each result word against the oldest prediction
  always @(posedge clk) begin
    color_t c;
    if (rst_n && out_valid) begin
      if (color_q.size() == 0) begin
        $error("result word with no prediction pending");
        err_cnt <= err_cnt + 1;
      end else begin
        c = color_q.pop_front();
        if (out_red !== c.red || out_green !== c.green || out_blue !== c.blue ||
            out_ok !== c.ok) begin
          err_cnt <= err_cnt + 1;
          if (out_red !== c.red) $error("red: expected %0d, got %0d", c.red, out_red);
          if (out_green !== c.green)
            $error("green: expected %0d, got %0d", c.green, out_green);
          if (out_blue !== c.blue) $error("blue: expected %0d, got %0d", c.blue, out_blue);
          if (out_ok !== c.ok) $error("ok: expected %0d, got %0d", c.ok, out_ok);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int lo, hi, span, s;
    pend_t p;
    build_sine_rom();
    // directed: reset settings, sample extremes, every mode
    foreach (sine_rom[k]) if (k < 8) add_word(24'(k * 40 - 20));
    add_word(24'h800000);
    add_word(24'h7FFFFF);
    for (int m = 0; m < 16; m++) begin
      add_setting(m[3:0], 24'd0, 24'd255);
      add_word(24'hFFFFFF);
      add_word(24'd128);
      add_word(24'd300);
      add_word(24'd200);
      if (m == 8 || m == 9) add_word(24'd700);
    end
    // empty and reversed ranges, full span
    add_setting(4'd2, 24'd100, 24'd100);
    add_word(24'd100);
    add_word(24'd5);
    add_setting(4'd6, 24'd1000, 24'hFFFC18);
    add_word(24'd0);
    add_word(24'd500);
    add_setting(4'd13, 24'h800000, 24'h7FFFFF);
    add_word(24'h800000);
    add_word(24'h7FFFFF);
    add_word(24'd0);
    // random settings, mostly samples around the configured range
    for (int ph = 0; ph < 40; ph++) begin
      case ($urandom_range(0, 7))
        0: begin lo = -8388608; hi = 8388607; end
        1: begin lo = $urandom_range(0, 2000) - 1000; hi = lo; end
        2: begin hi = $urandom_range(0, 4000) - 2000; lo = hi + $urandom_range(1, 3000); end
        3: begin lo = int'($urandom_range(0, 16777215)) - 8388608; hi = lo + 1; end
        default: begin
          lo = int'($urandom_range(0, 1000000)) - 500000;
          hi = lo + $urandom_range(1, 1 << $urandom_range(1, 20));
        end
      endcase
      if (hi > 8388607) hi = 8388607;
      add_setting(4'($urandom_range(0, 15)), 24'(lo), 24'(hi));
      burst = ($urandom_range(0, 3) == 0) ? 1 : 0;
      span = (hi > lo) ? hi - lo : lo - hi;
      for (int n = 0; n < 42; n++) begin
        if ($urandom_range(0, 5) == 0) begin
          add_word(24'($urandom));
        end else begin
          s = ((hi < lo) ? hi : lo) - span / 4 + int'($urandom_range(0, span + span / 2));
          add_word(24'(s));
        end
        if (ph == 5 && n == 20) begin
          p.op = OP_DRAIN; p.idx = CFG_MAP_MODE; p.val = '0; p.gap = 0;
          pend_q.insert(pend_q.size(), p);
        end
      end
      burst = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (pend_q.size() != 0 || start || color_q.size() != 0);
    repeat (70) @(posedge clk);
    if (err_cnt == 0) $display("scalar_to_false_color regression: pass");
    else $display("scalar_to_false_color regression: fail");
    $finish;
  end

  initial begin
    #5000000;
    $display("scalar_to_false_color regression: fail");
    $finish;
  end

endmodule
